FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// opcodes, function codes and the result item layout of the execute core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvie_pkg;

  // major opcodes
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_ALUI   = 7'b0010011;
  localparam logic [6:0] OP_ALUR   = 7'b0110011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  // branch conditions
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load and store sizes
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // alu operations
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;
  // region bit 26 of the word index is bit 28 of the byte address
  localparam int unsigned REGION_ADDR_BIT = 28;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [9:0]  mem_index;
    logic [31:0] mem_value;
    logic        error_flag;
  } result_t;

endpackage

FILE: hw/rtl/rvie_if.sv
// ----------------------------------------------------------------------------
// rvie_if
// valid/ready channels for instruction items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvie_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvie_result_if;
  logic              valid;
  logic              ready;
  rvie_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rv32i_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_core
// executes one RV32I instruction item and returns one result item
// ----------------------------------------------------------------------------
// instr_i carries the instruction word fetched at the last reported next_pc
// (zero after reset); result_o returns next_pc, the register write, the data
// store write and the sticky error flag for that instruction.
// pipeline: accept (register file read), execute (data store read),
// writeback (register file and data store write, result register loaded).
// the next item is taken in the writeback cycle of the previous one, its
// operands forwarded from that write. no item is taken while one is in
// execute, since every item passes through the synchronous data store read
// between execute and writeback.
// reset: the register file reads zero at once; the data store is cleared by
// a pass over all DATA_WORDS words during which no item is accepted.
// a stalled result_o holds its item; writeback waits, and instr_i.ready
// drops until the result register frees up.
// DATA_WORDS must be a power of two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_instruction_execute_core #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  rvie_instr_if.sink    instr_i,
  rvie_result_if.source result_o
);
  import rvie_pkg::*;

  localparam int unsigned DW_AW = $clog2(DATA_WORDS);

  typedef enum logic [1:0] {
    WB_PLAIN,
    WB_LOAD,
    WB_STORE
  } wb_kind_e;

  // handshake and stage control
  logic in_ready, accept, wb_done;
  logic clr_busy_q;
  logic [DW_AW-1:0] clr_addr_q;
  logic ex_v_q, wb_v_q, out_v_q;
  result_t out_q;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_q;
  logic [31:0] rf_rd1_q, rf_rd2_q;
  logic rs1_v_q, rs2_v_q;
  logic rf_we;
  logic fwd_v_q;
  logic [4:0] fwd_idx_q;
  logic [31:0] fwd_val_q;

  // data store
  logic [31:0] dm_mem [DATA_WORDS];
  logic [31:0] dm_rd_q;
  logic dm_we;

  // execute stage
  logic [31:0] ins_q, pc_q;
  logic err_q;
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd, rs1, rs2;
  logic [31:0] s1, s2, imm_i, imm_s, imm_b, imm_j, addr;
  logic [4:0] shamt;
  logic [DW_AW-1:0] ex_widx;
  logic [31:0] ex_res, ex_npc;
  logic ex_wr, ex_wm, ex_err, take;
  wb_kind_e ex_kind;

  // writeback stage
  wb_kind_e wb_kind_q;
  logic [2:0] wb_f3_q;
  logic [4:0] wb_rd_q;
  logic wb_wr_q, wb_wm_q, wb_err_q;
  logic [31:0] wb_res_q, wb_s2_q, wb_npc_q;
  logic [1:0] wb_lane_q;
  logic [DW_AW-1:0] wb_widx_q;
  logic [31:0] lane_word, load_res, merged, wb_value;
  logic [4:0] lane_sh;

  // handshake
  assign wb_done  = wb_v_q && (!out_v_q || result_o.ready);
  assign in_ready = !clr_busy_q && !ex_v_q && (!wb_v_q || wb_done);
  assign accept   = instr_i.valid && in_ready;
  assign instr_i.ready = in_ready;
  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  // clearing pass over the data store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == DW_AW'(DATA_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // register file memory, two read ports at accept
  assign rs1 = instr_i.instruction_word[19:15];
  assign rs2 = instr_i.instruction_word[24:20];

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[wb_rd_q] <= wb_value;
    end
    if (accept) begin
      rf_rd1_q <= rf_mem[rs1];
      rf_rd2_q <= rf_mem[rs2];
    end
  end

  // entry valid bits and last-write forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      rs1_v_q    <= 1'b0;
      rs2_v_q    <= 1'b0;
      fwd_v_q    <= 1'b0;
      fwd_idx_q  <= '0;
      fwd_val_q  <= '0;
    end else begin
      if (accept) begin
        rs1_v_q <= rf_valid_q[rs1];
        rs2_v_q <= rf_valid_q[rs2];
      end
      if (rf_we) begin
        rf_valid_q[wb_rd_q] <= 1'b1;
        fwd_v_q   <= 1'b1;
        fwd_idx_q <= wb_rd_q;
        fwd_val_q <= wb_value;
      end
    end
  end

  // stage valids, program counter and sticky error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q  <= 1'b0;
      wb_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pc_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      ex_v_q <= accept;
      if (ex_v_q) begin
        wb_v_q <= 1'b1;
      end else if (wb_done) begin
        wb_v_q <= 1'b0;
      end
      if (wb_done) begin
        out_v_q <= 1'b1;
        pc_q    <= wb_npc_q;
        err_q   <= err_q | wb_err_q;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q <= instr_i.instruction_word;
    end
  end

  // operand fields and immediates
  assign op = ins_q[6:0];
  assign f3 = ins_q[14:12];
  assign f7 = ins_q[31:25];
  assign rd = ins_q[11:7];

  assign s1 = (fwd_v_q && fwd_idx_q == ins_q[19:15]) ? fwd_val_q :
              (rs1_v_q ? rf_rd1_q : 32'd0);
  assign s2 = (fwd_v_q && fwd_idx_q == ins_q[24:20]) ? fwd_val_q :
              (rs2_v_q ? rf_rd2_q : 32'd0);

  assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
  assign imm_b = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign imm_j = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};

  assign addr    = s1 + ((op == OP_STORE) ? imm_s : imm_i);
  assign ex_widx = addr[DW_AW+1:2];

  // decode and execute
  always_comb begin
    ex_res  = 32'd0;
    ex_wr   = 1'b0;
    ex_wm   = 1'b0;
    ex_npc  = pc_q + 32'd4;
    ex_err  = (pc_q[1:0] != 2'b00);
    ex_kind = WB_PLAIN;
    take    = 1'b0;
    shamt   = 5'd0;
    case (op)
      OP_LUI: begin
        ex_res = ins_q & UPPER_MASK;
        ex_wr  = 1'b1;
      end
      OP_AUIPC: begin
        ex_res = (ins_q & UPPER_MASK) + pc_q;
        ex_wr  = 1'b1;
      end
      OP_JAL: begin
        ex_res = pc_q + 32'd4;
        ex_wr  = 1'b1;
        ex_npc = pc_q + imm_j;
      end
      OP_JALR: begin
        ex_res = pc_q + 32'd4;
        ex_wr  = 1'b1;
        ex_npc = s1 + imm_i;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (s1 == s2);
          F3_BNE:  take = (s1 != s2);
          F3_BLT:  take = ($signed(s1) < $signed(s2));
          F3_BGE:  take = !($signed(s1) < $signed(s2));
          F3_BLTU: take = (s1 < s2);
          F3_BGEU: take = (s1 >= s2);
          default: ex_err = 1'b1;
        endcase
        if (take) begin
          ex_npc = pc_q + imm_b;
        end
      end
      OP_LOAD: begin
        ex_kind = WB_LOAD;
        if (!addr[REGION_ADDR_BIT]) begin
          ex_err = 1'b1;
        end
        case (f3)
          F3_B, F3_BU, F3_W: ex_wr = 1'b1;
          F3_H, F3_HU:       ex_wr = !addr[0];
          default:           ex_err = 1'b1;
        endcase
      end
      OP_STORE: begin
        ex_kind = WB_STORE;
        if (!addr[REGION_ADDR_BIT]) begin
          ex_err = 1'b1;
        end
        case (f3)
          F3_B, F3_H, F3_W: ex_wm = 1'b1;
          default:          ex_err = 1'b1;
        endcase
      end
      OP_ALUI: begin
        shamt = imm_i[4:0];
        ex_wr = 1'b1;
        case (f3)
          F3_ADD:  ex_res = s1 + imm_i;
          F3_SLT:  ex_res = {31'd0, $signed(s1) < $signed(imm_i)};
          F3_SLTU: ex_res = {31'd0, s1 < imm_i};
          F3_XOR:  ex_res = s1 ^ imm_i;
          F3_OR:   ex_res = s1 | imm_i;
          F3_AND:  ex_res = s1 & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) begin
              ex_res = s1 << shamt;
            end else begin
              ex_err = 1'b1;
              ex_wr  = 1'b0;
            end
          end
          default: begin
            if (f7 == F7_BASE) begin
              ex_res = s1 >> shamt;
            end else if (f7 == F7_ALT) begin
              ex_res = 32'($signed(s1) >>> shamt);
            end else begin
              ex_err = 1'b1;
              ex_wr  = 1'b0;
            end
          end
        endcase
      end
      OP_ALUR: begin
        shamt = s2[4:0];
        ex_wr = 1'b1;
        if (f7 == F7_ALT && f3 == F3_ADD) begin
          ex_res = s1 - s2;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          ex_res = 32'($signed(s1) >>> shamt);
        end else if (f7 != F7_BASE) begin
          ex_err = 1'b1;
          ex_wr  = 1'b0;
        end else begin
          case (f3)
            F3_ADD:  ex_res = s1 + s2;
            F3_SLL:  ex_res = s1 << shamt;
            F3_SLT:  ex_res = {31'd0, $signed(s1) < $signed(s2)};
            F3_SLTU: ex_res = {31'd0, s1 < s2};
            F3_XOR:  ex_res = s1 ^ s2;
            F3_SR:   ex_res = s1 >> shamt;
            F3_OR:   ex_res = s1 | s2;
            default: ex_res = s1 & s2;
          endcase
        end
      end
      OP_FENCE: begin
      end
      OP_SYSTEM: begin
        if (ins_q[31:20] != 12'd0) begin
          ex_err = 1'b1;
        end
      end
      default: ex_err = 1'b1;
    endcase
  end

  // data store memory: clearing write, store write, execute-stage read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dm_mem[clr_addr_q] <= 32'd0;
    end else if (dm_we) begin
      dm_mem[wb_widx_q] <= merged;
    end
    if (ex_v_q) begin
      dm_rd_q <= dm_mem[ex_widx];
    end
  end

  // writeback stage registers
  always_ff @(posedge clk_i) begin
    if (ex_v_q) begin
      wb_kind_q <= ex_kind;
      wb_f3_q   <= f3;
      wb_rd_q   <= rd;
      wb_wr_q   <= ex_wr;
      wb_wm_q   <= ex_wm;
      wb_err_q  <= ex_err;
      wb_res_q  <= ex_res;
      wb_s2_q   <= s2;
      wb_npc_q  <= ex_npc;
      wb_lane_q <= addr[1:0];
      wb_widx_q <= ex_widx;
    end
  end

  // load extraction and store merge
  assign lane_sh   = {wb_lane_q, 3'b000};
  assign lane_word = dm_rd_q >> lane_sh;

  always_comb begin
    case (wb_f3_q)
      F3_B:    load_res = {{24{lane_word[7]}}, lane_word[7:0]};
      F3_BU:   load_res = {24'd0, lane_word[7:0]};
      F3_H:    load_res = {{16{lane_word[15]}}, lane_word[15:0]};
      F3_HU:   load_res = {16'd0, lane_word[15:0]};
      F3_W:    load_res = dm_rd_q;
      default: load_res = 32'd0;
    endcase
  end

  always_comb begin
    case (wb_f3_q)
      F3_B: merged = (dm_rd_q & ~(32'h0000_00FF << lane_sh)) |
                     ({24'd0, wb_s2_q[7:0]} << lane_sh);
      F3_H: begin
        if (!wb_lane_q[0]) begin
          merged = (dm_rd_q & ~(32'h0000_FFFF << lane_sh)) |
                   ({16'd0, wb_s2_q[15:0]} << lane_sh);
        end else begin
          merged = dm_rd_q;
        end
      end
      F3_W:    merged = wb_s2_q;
      default: merged = dm_rd_q;
    endcase
  end

  assign wb_value = (wb_kind_q == WB_LOAD) ? load_res : wb_res_q;
  assign rf_we    = wb_done && wb_wr_q && (wb_rd_q != 5'd0);
  assign dm_we    = wb_done && wb_wm_q;

  // result register
  always_ff @(posedge clk_i) begin
    if (wb_done) begin
      out_q.next_pc    <= wb_npc_q;
      out_q.reg_write  <= wb_wr_q;
      out_q.reg_index  <= wb_wr_q ? wb_rd_q : 5'd0;
      out_q.reg_value  <= wb_wr_q ? wb_value : 32'd0;
      out_q.mem_write  <= wb_wm_q;
      out_q.mem_index  <= wb_wm_q ? 10'(wb_widx_q) : 10'd0;
      out_q.mem_value  <= wb_wm_q ? merged : 32'd0;
      out_q.error_flag <= err_q | wb_err_q;
    end
  end

  // checks
`include "assert_macros.svh"

  `ASSERT_CLK(a_no_x0_write, !(rf_we && wb_rd_q == 5'd0), "write to x0 entry")
  `ASSERT_IMP(a_no_accept_clearing, clr_busy_q, !in_ready, "item taken during clear")
  `ASSERT_NXT(a_ex_advances, ex_v_q, wb_v_q, "execute item lost")
  `ASSERT_IMP(a_no_store_clearing, clr_busy_q, !wb_v_q, "writeback during clear")

endmodule

FILE: tb/rvie_result_checker.sv
// ----------------------------------------------------------------------------
// rvie_result_checker
// watches both channels, predicts each result item and compares it
// ----------------------------------------------------------------------------
// every accepted instruction item is executed on a private copy of the
// register file, program counter, data store and error flag; the expected
// result item is queued and matched in order against accepted result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvie_result_checker
  import rvie_pkg::*;
#(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rvie_instr_if  instr_i,
  rvie_result_if result_i,
  output int     fail_count_o,
  output int     pending_o
);

  logic [31:0] gpr [32];
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] pc_q;
  logic        err_q;
  result_t     expected_results [$];

  // execute one instruction on the shadow state
  task automatic execute_instr(input logic [31:0] ins, output result_t r);
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] s1, s2, pc, npc, imm_i, imm_s, imm_b, imm_j;
    logic [31:0] res, mval, addr, word, cur, lane_b, lane_h;
    logic [1:0]  lane;
    logic [9:0]  widx;
    logic [4:0]  sh;
    logic        wr, wm, bad, take;
    op = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    rd = ins[11:7];
    s1 = gpr[ins[19:15]];
    s2 = gpr[ins[24:20]];
    pc = pc_q;
    npc = pc + 32'd4;
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    res = '0; mval = '0; widx = '0;
    wr = 1'b0; wm = 1'b0; take = 1'b0;
    bad = (pc[1:0] != 2'b00);
    case (op)
      OP_LUI: begin
        res = ins & UPPER_MASK; wr = 1'b1;
      end
      OP_AUIPC: begin
        res = (ins & UPPER_MASK) + pc; wr = 1'b1;
      end
      OP_JAL: begin
        res = pc + 32'd4; wr = 1'b1; npc = pc + imm_j;
      end
      OP_JALR: begin
        res = pc + 32'd4; wr = 1'b1; npc = s1 + imm_i;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (s1 == s2);
          F3_BNE:  take = (s1 != s2);
          F3_BLT:  take = ($signed(s1) < $signed(s2));
          F3_BGE:  take = ($signed(s1) >= $signed(s2));
          F3_BLTU: take = (s1 < s2);
          F3_BGEU: take = (s1 >= s2);
          default: bad = 1'b1;
        endcase
        if (take) npc = pc + imm_b;
      end
      OP_LOAD, OP_STORE: begin
        addr = s1 + ((op == OP_LOAD) ? imm_i : imm_s);
        word = addr >> 2;
        lane = addr[1:0];
        if (!word[26]) bad = 1'b1;
        widx = word[9:0];
        cur = dmem[widx];
        lane_b = (cur >> (8 * lane)) & 32'hFF;
        lane_h = (cur >> (8 * lane)) & 32'hFFFF;
        if (op == OP_LOAD) begin
          case (f3)
            F3_B:  begin res = {{24{lane_b[7]}}, lane_b[7:0]}; wr = 1'b1; end
            F3_BU: begin res = lane_b; wr = 1'b1; end
            F3_H:  if (!lane[0]) begin res = {{16{lane_h[15]}}, lane_h[15:0]}; wr = 1'b1; end
            F3_HU: if (!lane[0]) begin res = lane_h; wr = 1'b1; end
            F3_W:  begin res = cur; wr = 1'b1; end
            default: bad = 1'b1;
          endcase
        end else begin
          case (f3)
            F3_B: begin
              mval = (cur & ~(32'hFF << (8 * lane))) | ((s2 & 32'hFF) << (8 * lane));
              wm = 1'b1;
            end
            F3_H: begin
              mval = cur;
              if (!lane[0])
                mval = (cur & ~(32'hFFFF << (8 * lane))) | ((s2 & 32'hFFFF) << (8 * lane));
              wm = 1'b1;
            end
            F3_W: begin mval = s2; wm = 1'b1; end
            default: bad = 1'b1;
          endcase
        end
      end
      OP_ALUI: begin
        sh = imm_i[4:0];
        wr = 1'b1;
        case (f3)
          F3_ADD:  res = s1 + imm_i;
          F3_SLT:  res = {31'd0, $signed(s1) < $signed(imm_i)};
          F3_SLTU: res = {31'd0, s1 < imm_i};
          F3_XOR:  res = s1 ^ imm_i;
          F3_OR:   res = s1 | imm_i;
          F3_AND:  res = s1 & imm_i;
          F3_SLL:  if (f7 == F7_BASE) res = s1 << sh; else begin bad = 1'b1; wr = 1'b0; end
          default: begin
            if (f7 == F7_BASE) res = s1 >> sh;
            else if (f7 == F7_ALT) res = $signed(s1) >>> sh;
            else begin bad = 1'b1; wr = 1'b0; end
          end
        endcase
      end
      OP_ALUR: begin
        sh = s2[4:0];
        wr = 1'b1;
        if (f7 == F7_ALT && f3 == F3_ADD) res = s1 - s2;
        else if (f7 == F7_ALT && f3 == F3_SR) res = $signed(s1) >>> sh;
        else if (f7 != F7_BASE) begin bad = 1'b1; wr = 1'b0; end
        else begin
          case (f3)
            F3_ADD:  res = s1 + s2;
            F3_SLL:  res = s1 << sh;
            F3_SLT:  res = {31'd0, $signed(s1) < $signed(s2)};
            F3_SLTU: res = {31'd0, s1 < s2};
            F3_XOR:  res = s1 ^ s2;
            F3_SR:   res = s1 >> sh;
            F3_OR:   res = s1 | s2;
            default: res = s1 & s2;
          endcase
        end
      end
      OP_FENCE: ;
      OP_SYSTEM: if (ins[31:20] != 12'd0) bad = 1'b1;
      default: bad = 1'b1;
    endcase
    // commit shadow state
    if (wr && rd != 5'd0) gpr[rd] = res;
    if (wm) dmem[widx] = mval;
    if (bad) err_q = 1'b1;
    pc_q = npc;
    r.next_pc    = npc;
    r.reg_write  = wr;
    r.reg_index  = wr ? rd : 5'd0;
    r.reg_value  = wr ? res : 32'd0;
    r.mem_write  = wm;
    r.mem_index  = wm ? widx : 10'd0;
    r.mem_value  = wm ? mval : 32'd0;
    r.error_flag = err_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // predict on instruction items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t act_r;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
      pc_q = '0;
      err_q = 1'b0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (instr_i.valid && instr_i.ready) begin
        execute_instr(instr_i.instruction_word, exp_r);
        expected_results.push_back(exp_r);
      end
      if (result_i.valid && result_i.ready) begin
        act_r = result_i.data;
        if (expected_results.size() == 0) begin
          $error("result item with no instruction item outstanding");
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("next_pc",    exp_r.next_pc,    act_r.next_pc);
          check_field("reg_write",  exp_r.reg_write,  act_r.reg_write);
          check_field("reg_index",  exp_r.reg_index,  act_r.reg_index);
          check_field("reg_value",  exp_r.reg_value,  act_r.reg_value);
          check_field("mem_write",  exp_r.mem_write,  act_r.mem_write);
          check_field("mem_index",  exp_r.mem_index,  act_r.mem_index);
          check_field("mem_value",  exp_r.mem_value,  act_r.mem_value);
          check_field("error_flag", exp_r.error_flag, act_r.error_flag);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: tb/rv32i_instruction_execute_core_tb.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_core_tb
// stimulus and verdict for the rv32i execute core
// ----------------------------------------------------------------------------
// a directed program covers stores in every lane, loads in lanes 0 to 2,
// several alu ops, branches and a jump; random programs built around base
// pointers in the valid data region follow, noise words and error cases at the end.
// the checker beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_instruction_execute_core_tb;
  import rvie_pkg::*;

  localparam int unsigned IDLE_LIMIT = 8000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   burst_left;
  bit   hold_req;
  bit   hold_taken;
  int   hold_left;
  int   rx_phase;

  rvie_instr_if  instr_ch ();
  rvie_result_if result_ch ();

  rv32i_instruction_execute_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_ch),
    .result_o(result_ch)
  );

  rvie_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .instr_i     (instr_ch),
    .result_i    (result_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // random instruction; x1..x3 hold data pointers and are left alone
  function automatic logic [31:0] random_instr();
    logic [4:0]  rd, rs1, rs2, base;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] w;
    int          pick;
    rd   = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(4, 31));
    rs1  = 5'($urandom_range(0, 31));
    rs2  = 5'($urandom_range(0, 31));
    base = 5'($urandom_range(1, 3));
    f3   = 3'($urandom_range(0, 7));
    f7   = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
           ($urandom_range(0, 1) ? F7_ALT : F7_BASE);
    pick = $urandom_range(0, 99);
    if (pick < 20) w = enc_r(f7, rs2, rs1, f3, rd, OP_ALUR);
    else if (pick < 38) begin
      w = enc_i(12'($urandom), rs1, f3, rd, OP_ALUI);
      if (f3 == F3_SLL || f3 == F3_SR) w[31:25] = f7;
    end
    else if (pick < 42) w = {20'($urandom), rd, OP_LUI};
    else if (pick < 45) w = {20'($urandom), rd, OP_AUIPC};
    else if (pick < 54) begin
      if ($urandom_range(0, 9) == 0) f3 = 3'($urandom_range(2, 3));
      else if (f3 == 3'd2 || f3 == 3'd3) f3 = F3_BEQ;
      w = enc_b({13'($urandom) & 13'h1FFC}, rs2, rs1, f3);
    end
    else if (pick < 57) w = enc_j(21'($urandom) & 21'h1FFFFC, rd);
    else if (pick < 60) begin
      // jump via a register, usually to an aligned target
      w = enc_i($urandom_range(0, 3) ? 12'd0 : 12'($urandom), base, f3, rd, OP_JALR);
    end
    else if (pick < 77) begin
      if ($urandom_range(0, 19) == 0) f3 = 3'($urandom_range(6, 7));
      else if (f3 == 3'd3 || f3 > 3'd5) f3 = F3_W;
      w = enc_i(12'($urandom), $urandom_range(0, 9) ? base : rs1, f3, rd, OP_LOAD);
    end
    else if (pick < 93) begin
      if ($urandom_range(0, 19) == 0) f3 = 3'($urandom_range(3, 7));
      else f3 = 3'($urandom_range(0, 2));
      w = enc_s(12'($urandom), rs2, $urandom_range(0, 9) ? base : rs1, f3);
    end
    else if (pick < 95) w = {25'($urandom), OP_FENCE};
    else if (pick < 97) w = {12'd0, 13'($urandom), OP_SYSTEM};
    else w = $urandom;
    return w;
  endfunction

  // offer one instruction item; sender runs in bursts with gaps
  task automatic send_instr(input logic [31:0] w);
    if (burst_left == 0) begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    instr_ch.valid <= 1'b1;
    instr_ch.instruction_word <= w;
    @(posedge clk_i iff instr_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    instr_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // idle margin covering the pipeline depth
    repeat (6) @(negedge clk_i);
  endtask

  // receiver stalls on its own pattern, plus one long hold
  always @(negedge clk_i) begin
    rx_phase <= (rx_phase + 1) % 128;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      result_ch.ready <= 1'b0;
    end else if (rx_phase < 40) result_ch.ready <= 1'b1;
    else if (rx_phase < 90) result_ch.ready <= ($urandom_range(0, 3) != 0);
    else result_ch.ready <= ($urandom_range(0, 1) != 0);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rv32i_instruction_execute_core regression: fail");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_ni = 1'b0;
    instr_ch.valid = 1'b0;
    instr_ch.instruction_word = '0;
    result_ch.ready = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    rx_phase = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed program: pointers, lanes, alu, branches, a jump
    send_instr({20'h10000, 5'd1, OP_LUI});
    send_instr({20'h7FFFF, 5'd2, OP_LUI});
    send_instr({20'h1FFFF, 5'd3, OP_LUI});
    send_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd4, OP_ALUI));
    send_instr(enc_s(12'd0, 5'd4, 5'd1, F3_W));
    send_instr(enc_s(12'd1, 5'd0, 5'd1, F3_B));
    send_instr(enc_i(12'd0, 5'd1, F3_B, 5'd5, OP_LOAD));
    send_instr(enc_i(12'd1, 5'd1, F3_BU, 5'd6, OP_LOAD));
    send_instr(enc_i(12'd2, 5'd1, F3_H, 5'd7, OP_LOAD));
    send_instr(enc_i(12'd2, 5'd1, F3_HU, 5'd8, OP_LOAD));
    send_instr(enc_i(12'd1, 5'd1, F3_H, 5'd9, OP_LOAD));
    send_instr(enc_s(12'd3, 5'd4, 5'd1, F3_H));
    send_instr(enc_s(12'hFFE, 5'd5, 5'd2, F3_H));
    send_instr(enc_i(12'd1, 5'd1, F3_W, 5'd10, OP_LOAD));
    send_instr(enc_r(F7_BASE, 5'd4, 5'd4, F3_ADD, 5'd0, OP_ALUR));
    send_instr(enc_r(F7_ALT, 5'd4, 5'd0, F3_ADD, 5'd11, OP_ALUR));
    send_instr(enc_r(F7_ALT, 5'd4, 5'd4, F3_SR, 5'd12, OP_ALUR));
    send_instr(enc_i({F7_ALT, 5'd31}, 5'd4, F3_SR, 5'd13, OP_ALUI));
    send_instr(enc_i({F7_BASE, 5'd31}, 5'd4, F3_SLL, 5'd14, OP_ALUI));
    send_instr(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ));
    send_instr(enc_b(13'h1FF8, 5'd4, 5'd0, F3_BLT));
    send_instr(enc_b(13'd16, 5'd0, 5'd4, F3_BGEU));
    send_instr(enc_j(21'h100000, 5'd15));
    send_instr({20'hFFFFF, 5'd16, OP_AUIPC});
    send_instr({25'd0, OP_FENCE});
    send_instr({25'd0, OP_SYSTEM});
    drain();

    // random programs; one long receiver hold, one full drain after 600 items
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 600) drain();
      send_instr(random_instr());
    end
    drain();

    // error cases: bad region, breakpoint, unknown word, misaligned pc
    send_instr(enc_i(12'd0, 5'd0, F3_W, 5'd18, OP_LOAD));
    send_instr({12'd1, 13'd0, OP_SYSTEM});
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_i(12'd1, 5'd0, F3_ADD, 5'd0, OP_JALR));
    send_instr(enc_i(12'd5, 5'd0, F3_ADD, 5'd19, OP_ALUI));
    for (int n = 0; n < 40; n++) send_instr(random_instr());
    drain();

    if (fail_count == 0) $display("rv32i_instruction_execute_core regression: pass");
    else $display("rv32i_instruction_execute_core regression: fail");
    $finish;
  end

endmodule
